// File: sv/trbox_pkg.sv
// shared constants for the triangle / box overlap block
package trbox_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// configuration register indexes
	localparam int CFG_IDX_W      = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_Z = 2'd2;

	// vertex pair per edge (row) and axis (column) for the edge-cross-axis tests
	localparam int VP_FIRST [3][3]  = '{'{0, 0, 1}, '{0, 0, 0}, '{0, 0, 1}};
	localparam int VP_SECOND [3][3] = '{'{2, 2, 2}, '{2, 2, 1}, '{1, 1, 2}};

endpackage

// File: sv/triangle_box_overlap_test.sv
// triangle / axis-aligned box overlap test, eight-stage pipeline
//
// Input stream s_*: one item per accepted beat holds three triangle vertices
// and a box center, signed fixed point, packed in s_tdata. Result stream m_*:
// one item per input, m_tdata[0] is the overlap flag (1 = overlap).
// Box half extents come from the cfg_* write channel (index 0..2 = x, y, z)
// and must be written only while no item is in flight; nothing enforces it.
// cfg_ready is always high. An accepted item passes through register stages
// s1 to s8, and m_tvalid follows vld_s8. One item can enter each cycle while
// the receiver does not stall the pipe, as each of the eight register stages
// takes its share of the wide multiplies and adds.
// Each stage holds its item while the next is full and stalled, so a bubble
// is squeezed out and a stalled receiver backs up the pipe without loss;
// s_tready falls only when every stage is occupied.
// Reset clears all valid bits and loads half extents of one half unit.
module triangle_box_overlap_test #(
	parameter int COORD_BITS = trbox_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = trbox_pkg::FRAC_BITS_DEF,
	localparam int TDW = ((12 * COORD_BITS + 7) / 8) * 8,
	localparam int CDW = ((COORD_BITS - 1 + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vertex_a_x,y,z, vertex_b_x,y,z, vertex_c_x,y,z, center_x,y,z, zero fill
	input  logic [TDW-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// overlaps, zero fill
	output logic [7:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [trbox_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CDW-1:0] cfg_data
);

	localparam int CB  = COORD_BITS;
	localparam int HW  = CB - 1;
	localparam int WP  = 2 * CB + 4;
	localparam int W4  = 2 * CB + 5;
	localparam int WN  = 2 * CB + 5;
	localparam int WL  = CB + 2;
	localparam int WNH = WN - WL;
	localparam int WQ  = 2 * CB + 6;
	localparam int WD  = 3 * CB + 10;
	localparam logic [HW-1:0] HALF_RST =
		(FRAC_BITS > 0) ? HW'(64'd1 << (FRAC_BITS - 1)) : '0;

	logic [HW-1:0] half_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) half_q[k] <= HALF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				trbox_pkg::REG_HALF_X: half_q[0] <= cfg_data[HW-1:0];
				trbox_pkg::REG_HALF_Y: half_q[1] <= cfg_data[HW-1:0];
				trbox_pkg::REG_HALF_Z: half_q[2] <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// signed views of the half extents
	logic signed [CB:0] hs [3];
	always_comb begin
		for (int k = 0; k < 3; k++) hs[k] = $signed({2'b00, half_q[k]});
	end

	// stage handshake
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	assign en_s8 = !vld_s8 || m_tready;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
		end
	end

	// stage 1: vertices relative to the box center
	logic signed [CB:0] v_s1 [3][3];

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			for (int t = 0; t < 3; t++) begin
				for (int k = 0; k < 3; k++) begin
					v_s1[t][k] <= $signed({s_tdata[(t*3+k)*CB + CB-1], s_tdata[(t*3+k)*CB +: CB]})
						- $signed({s_tdata[(9+k)*CB + CB-1], s_tdata[(9+k)*CB +: CB]});
				end
			end
		end
	end

	// stage 2: edges, their magnitudes, box-face tests
	logic signed [CB:0]   v_s2 [3][3];
	logic signed [CB+1:0] e_s2 [3][3];
	logic [CB+1:0]        ae_s2 [3][3];
	logic                 face_s2;

	logic signed [CB+1:0] e_c [3][3];
	logic                 face_c;
	always_comb begin
		logic above, below;
		face_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			e_c[0][k] = (CB+2)'(v_s1[1][k]) - (CB+2)'(v_s1[0][k]);
			e_c[1][k] = (CB+2)'(v_s1[2][k]) - (CB+2)'(v_s1[1][k]);
			e_c[2][k] = (CB+2)'(v_s1[0][k]) - (CB+2)'(v_s1[2][k]);
		end
		for (int k = 0; k < 3; k++) begin
			above = 1'b1;
			below = 1'b1;
			for (int t = 0; t < 3; t++) begin
				if (!(v_s1[t][k] > hs[k])) above = 1'b0;
				if (!(v_s1[t][k] < -hs[k])) below = 1'b0;
			end
			if (above || below) face_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			v_s2    <= v_s1;
			e_s2    <= e_c;
			face_s2 <= face_c;
			for (int t = 0; t < 3; t++) begin
				for (int k = 0; k < 3; k++) begin
					ae_s2[t][k] <= e_c[t][k][CB+1] ? (CB+2)'(-e_c[t][k]) : e_c[t][k];
				end
			end
		end
	end

	// stage 3: all products of the edge tests and the normal
	logic signed [WP-1:0] pa_s3 [3][3], pb_s3 [3][3], qa_s3 [3][3], qb_s3 [3][3];
	logic signed [WP-1:0] ra_s3 [3][3], rb_s3 [3][3];
	logic signed [WP-1:0] na_s3 [3], nb_s3 [3];
	logic signed [CB:0]   v0_s3 [3];
	logic                 face_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			face_s3 <= face_s2;
			v0_s3   <= v_s2[0];
			for (int t = 0; t < 3; t++) begin
				for (int k = 0; k < 3; k++) begin
					pa_s3[t][k] <= WP'(e_s2[t][(k+2)%3])
						* WP'(v_s2[trbox_pkg::VP_FIRST[t][k]][(k+1)%3]);
					pb_s3[t][k] <= WP'(e_s2[t][(k+1)%3])
						* WP'(v_s2[trbox_pkg::VP_FIRST[t][k]][(k+2)%3]);
					qa_s3[t][k] <= WP'(e_s2[t][(k+2)%3])
						* WP'(v_s2[trbox_pkg::VP_SECOND[t][k]][(k+1)%3]);
					qb_s3[t][k] <= WP'(e_s2[t][(k+1)%3])
						* WP'(v_s2[trbox_pkg::VP_SECOND[t][k]][(k+2)%3]);
					ra_s3[t][k] <= WP'($signed({1'b0, ae_s2[t][(k+2)%3]}))
						* WP'(hs[(k+1)%3]);
					rb_s3[t][k] <= WP'($signed({1'b0, ae_s2[t][(k+1)%3]}))
						* WP'(hs[(k+2)%3]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				na_s3[k] <= WP'(e_s2[0][(k+1)%3]) * WP'(e_s2[1][(k+2)%3]);
				nb_s3[k] <= WP'(e_s2[0][(k+2)%3]) * WP'(e_s2[1][(k+1)%3]);
			end
		end
	end

	// stage 4: projections, projected radius, normal
	logic signed [W4-1:0] p_s4 [3][3], q_s4 [3][3], r_s4 [3][3];
	logic signed [WN-1:0] n_s4 [3];
	logic signed [CB:0]   v0_s4 [3];
	logic                 face_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			face_s4 <= face_s3;
			v0_s4   <= v0_s3;
			for (int t = 0; t < 3; t++) begin
				for (int k = 0; k < 3; k++) begin
					p_s4[t][k] <= W4'(pa_s3[t][k]) - W4'(pb_s3[t][k]);
					q_s4[t][k] <= W4'(qa_s3[t][k]) - W4'(qb_s3[t][k]);
					r_s4[t][k] <= W4'(ra_s3[t][k]) + W4'(rb_s3[t][k]);
				end
			end
			for (int k = 0; k < 3; k++) n_s4[k] <= WN'(na_s3[k]) - WN'(nb_s3[k]);
		end
	end

	// stage 5: edge-axis verdicts, plane corner offsets, normal split in halves
	logic                  sep_s5;
	logic [WL-1:0]         nl_s5 [3];
	logic signed [WNH-1:0] nh_s5 [3];
	logic signed [WL-1:0]  lo_s5 [3], hi_s5 [3];

	logic edge_c;
	always_comb begin
		edge_c = 1'b0;
		for (int t = 0; t < 3; t++) begin
			for (int k = 0; k < 3; k++) begin
				if ((p_s4[t][k] > r_s4[t][k] && q_s4[t][k] > r_s4[t][k])
					|| (p_s4[t][k] < -r_s4[t][k] && q_s4[t][k] < -r_s4[t][k]))
					edge_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			sep_s5 <= face_s4 || edge_c;
			for (int k = 0; k < 3; k++) begin
				nl_s5[k] <= n_s4[k][WL-1:0];
				nh_s5[k] <= n_s4[k][WN-1:WL];
				// positive normal picks the negative corner for the minimum
				if (n_s4[k] > 0) begin
					lo_s5[k] <= WL'(-hs[k]) - WL'(v0_s4[k]);
					hi_s5[k] <= WL'(hs[k]) - WL'(v0_s4[k]);
				end else begin
					lo_s5[k] <= WL'(hs[k]) - WL'(v0_s4[k]);
					hi_s5[k] <= WL'(-hs[k]) - WL'(v0_s4[k]);
				end
			end
		end
	end

	// stage 6: partial products of normal times corner offset
	logic signed [WQ-1:0] llo_s6 [3], hlo_s6 [3], lhi_s6 [3], hhi_s6 [3];
	logic                 sep_s6;

	always_ff @(posedge clk) begin
		if (en_s6 && vld_s5) begin
			sep_s6 <= sep_s5;
			for (int k = 0; k < 3; k++) begin
				llo_s6[k] <= WQ'($signed({1'b0, nl_s5[k]})) * WQ'(lo_s5[k]);
				hlo_s6[k] <= WQ'(nh_s5[k]) * WQ'(lo_s5[k]);
				lhi_s6[k] <= WQ'($signed({1'b0, nl_s5[k]})) * WQ'(hi_s5[k]);
				hhi_s6[k] <= WQ'(nh_s5[k]) * WQ'(hi_s5[k]);
			end
		end
	end

	// stage 7: plane distance extremes
	logic signed [WD-1:0] dmin_s7, dmax_s7;
	logic                 sep_s7;

	logic signed [WD-1:0] dmin_c, dmax_c;
	always_comb begin
		dmin_c = '0;
		dmax_c = '0;
		for (int k = 0; k < 3; k++) begin
			dmin_c = dmin_c + (WD'(hlo_s6[k]) <<< WL) + WD'(llo_s6[k]);
			dmax_c = dmax_c + (WD'(hhi_s6[k]) <<< WL) + WD'(lhi_s6[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && vld_s6) begin
			sep_s7  <= sep_s6;
			dmin_s7 <= dmin_c;
			dmax_s7 <= dmax_c;
		end
	end

	// stage 8: output register
	logic ovl_s8;

	always_ff @(posedge clk) begin
		if (en_s8 && vld_s7) begin
			ovl_s8 <= !sep_s7 && !(dmin_s7 > 0) && !dmax_s7[WD-1];
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {7'd0, ovl_s8};

endmodule

// File: sv/trbox_check.sv
// port-level checks for the triangle / box overlap block, with bind
module trbox_check (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       cfg_ready
);

	// a waiting result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// an empty output stage means the whole pipe can move
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// only the flag bit carries data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("fill bits of result not zero");

	// nothing comes out right after reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid straight out of reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

endmodule

bind triangle_box_overlap_test trbox_check u_trbox_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_ready(cfg_ready)
);

// File: bench/triangle_box_overlap_test_test.sv
// self-checking testbench for the triangle / box overlap block
module triangle_box_overlap_test_test;

	localparam int CB = 32;
	localparam int TDW = 384;
	localparam int CDW = 32;
	localparam int LATENCY = 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [trbox_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic signed [127:0] acc_t;

	typedef struct {
		logic [31:0] f [12];
		int          want; // -1: use predictor
	} tri_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [TDW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [trbox_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CDW-1:0] cfg_data;

	triangle_box_overlap_test u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [30:0] half_ext [3];
	bit overlap_q [$];
	int errors;
	int idle_cycles;
	bit timed_out;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic acc_t sx(logic [31:0] v);
		return acc_t'($signed(v));
	endfunction

	function automatic acc_t abs_of(acc_t v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit apart(acc_t p, acc_t q, acc_t r);
		return (p > r && q > r) || (p < -r && q < -r);
	endfunction

	function automatic bit overlap_of(logic [31:0] f [12]);
		acc_t v [3][3];
		acc_t e [3][3];
		acc_t h [3];
		acc_t n [3];
		acc_t p, q, r, dmin, dmax, lo, hi;
		int vp1 [3][3];
		int vp2 [3][3];
		int i, j;
		bit above, below, pos;
		vp1 = '{'{0, 0, 1}, '{0, 0, 0}, '{0, 0, 1}};
		vp2 = '{'{2, 2, 2}, '{2, 2, 1}, '{1, 1, 2}};
		for (int k = 0; k < 3; k++) h[k] = acc_t'({1'b0, half_ext[k]});
		for (int t = 0; t < 3; t++)
			for (int k = 0; k < 3; k++) v[t][k] = sx(f[t*3+k]) - sx(f[9+k]);
		for (int k = 0; k < 3; k++) begin
			e[0][k] = v[1][k] - v[0][k];
			e[1][k] = v[2][k] - v[1][k];
			e[2][k] = v[0][k] - v[2][k];
		end
		for (int t = 0; t < 3; t++)
			for (int k = 0; k < 3; k++) begin
				i = (k + 1) % 3;
				j = (k + 2) % 3;
				p = e[t][j] * v[vp1[t][k]][i] - e[t][i] * v[vp1[t][k]][j];
				q = e[t][j] * v[vp2[t][k]][i] - e[t][i] * v[vp2[t][k]][j];
				r = abs_of(e[t][j]) * h[i] + abs_of(e[t][i]) * h[j];
				if (apart(p, q, r)) return 0;
			end
		for (int k = 0; k < 3; k++) begin
			above = 1;
			below = 1;
			for (int t = 0; t < 3; t++) begin
				if (!(v[t][k] > h[k])) above = 0;
				if (!(v[t][k] < -h[k])) below = 0;
			end
			if (above || below) return 0;
		end
		for (int k = 0; k < 3; k++) begin
			i = (k + 1) % 3;
			j = (k + 2) % 3;
			n[k] = e[0][i] * e[1][j] - e[0][j] * e[1][i];
		end
		dmin = 0;
		dmax = 0;
		for (int a = 0; a < 3; a++) begin
			pos = n[a] > 0;
			lo = (pos ? -h[a] : h[a]) - v[0][a];
			hi = (pos ? h[a] : -h[a]) - v[0][a];
			dmin += n[a] * lo;
			dmax += n[a] * hi;
		end
		if (dmin > 0) return 0;
		return dmax >= 0;
	endfunction

	// result side: random stall pattern, checks in order
	initial begin
		int mode;
		m_tready = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
			case (mode)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 3) != 0;
				default: m_tready <= $urandom_range(0, 2) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (overlap_q.size() == 0) begin
				$display("%0t: unexpected item, actual overlaps=%0d", $time, m_tdata[0]);
				errors++;
			end else begin
				bit want;
				want = overlap_q.pop_front();
				if (m_tdata[0] !== want) begin
					$display("%0t: overlaps expected %0d actual %0d", $time, want, m_tdata[0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("triangle_box_overlap_test test failed");
			$finish;
		end
	end

	task automatic write_reg(logic [trbox_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= trbox_pkg::REG_HALF_Z) half_ext[idx] = val[30:0];
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	// stop sending and wait until every expected item has come out
	task automatic drain_pipe();
		s_tvalid <= 0;
		while (overlap_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	int burst_left;

	// one item, sent in bursts with random gaps
	task automatic send_tri(logic [31:0] f [12], int want);
		bit pred;
		if (burst_left == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		for (int k = 0; k < 12; k++) s_tdata[k*CB +: CB] <= f[k];
		s_tvalid <= 1;
		pred = overlap_of(f);
		if (want >= 0 && want != pred) begin
			$display("%0t: table row expected %0d predictor %0d", $time, want, pred);
			errors++;
		end
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		overlap_q.insert(overlap_q.size(), want >= 0 ? bit'(want) : pred);
		burst_left--;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(int scale);
		case (scale)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
			default: return 32'($signed($urandom_range(0, 32'h30)) - 32'sh18) << 14;
		endcase
	endfunction

	localparam logic [31:0] MAXP = 32'h7fff_ffff;
	localparam logic [31:0] MINN = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] HALF = 32'h0000_8000;
	localparam logic [31:0] NONE = 32'hffff_0000;

	tri_row_t dir_rows [$];

	initial begin
		tri_row_t row;
		logic [31:0] f [12];
		int scale;
		errors = 0;
		burst_left = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = trbox_pkg::REG_HALF_X;
		cfg_data = '0;
		for (int k = 0; k < 3; k++) half_ext[k] = 31'd32768;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed rows at reset half extents
		row.f = '{HALF, 0, 0, 0, HALF, 0, 0, 0, HALF, 0, 0, 0}; row.want = 1;
		dir_rows.insert(dir_rows.size(), row);
		// far away on x
		row.f = '{ONE*4, 0, 0, ONE*4, ONE, 0, ONE*4, 0, ONE, 0, 0, 0}; row.want = 0;
		dir_rows.insert(dir_rows.size(), row);
		// touching face x = 0.5
		row.f = '{HALF, 0, 0, HALF, ONE, 0, HALF, 0, ONE, 0, 0, 0}; row.want = 1;
		dir_rows.insert(dir_rows.size(), row);
		// just past face
		row.f = '{HALF+1, 0, 0, HALF+1, ONE, 0, HALF+1, 0, ONE, 0, 0, 0}; row.want = 0;
		dir_rows.insert(dir_rows.size(), row);
		// degenerate point inside
		row.f = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}; row.want = 1;
		dir_rows.insert(dir_rows.size(), row);
		// degenerate point outside below
		row.f = '{NONE, 0, 0, NONE, 0, 0, NONE, 0, 0, 0, 0, 0}; row.want = 0;
		dir_rows.insert(dir_rows.size(), row);
		// plane misses the box corner
		row.f = '{ONE*2, 0, 0, 0, ONE*2, 0, 0, 0, ONE*2, 0, 0, 0}; row.want = -1;
		dir_rows.insert(dir_rows.size(), row);
		// extremes
		row.f = '{MAXP, MINN, MAXP, MINN, MAXP, MINN, MAXP, MAXP, MINN, MINN, MAXP, 0};
		row.want = -1; dir_rows.insert(dir_rows.size(), row);
		row.f = '{MINN, MINN, MINN, MAXP, MAXP, MAXP, MINN, MAXP, 0, MAXP, MINN, MAXP};
		row.want = -1; dir_rows.insert(dir_rows.size(), row);
		row.f = '{MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MINN, MINN, MINN};
		row.want = 0; dir_rows.insert(dir_rows.size(), row);
		row.f = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1, 1, 1,
			32'hffffffff, 32'hffffffff, 32'hffffffff};
		row.want = 1; dir_rows.insert(dir_rows.size(), row);
		foreach (dir_rows[r]) send_tri(dir_rows[r].f, dir_rows[r].want);

		// zero and maximum extents, plus an ignored index
		drain_pipe();
		write_reg(trbox_pkg::REG_HALF_X, 0);
		write_reg(trbox_pkg::REG_HALF_Y, 0);
		write_reg(trbox_pkg::REG_HALF_Z, 0);
		write_reg(REG_UNUSED, 32'h1234);
		f = '{HALF, 0, 0, 0, HALF, 0, 0, 0, HALF, 0, 0, 0};
		send_tri(f, -1);
		f = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_tri(f, 1);
		drain_pipe();
		write_reg(trbox_pkg::REG_HALF_X, 32'hffff_ffff);
		write_reg(trbox_pkg::REG_HALF_Y, 32'hffff_ffff);
		write_reg(trbox_pkg::REG_HALF_Z, 32'hffff_ffff);
		f = '{MAXP, MAXP, MAXP, MAXP, MINN, MAXP, MINN, MAXP, MAXP, MINN, MINN, MINN};
		send_tri(f, -1);
		f = '{MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MAXP, MAXP, MAXP};
		send_tri(f, 0);

		// random phases with fresh extents
		for (int ph = 0; ph < 6; ph++) begin
			drain_pipe();
			scale = ph % 3;
			for (int k = 0; k < 3; k++)
				write_reg(k[trbox_pkg::CFG_IDX_W-1:0], scale == 0 ? $urandom :
					$urandom_range(0, 32'h2_0000));
			for (int n = 0; n < 90; n++) begin
				for (int k = 0; k < 12; k++) f[k] = rnd_coord(scale);
				if (n == 45) drain_pipe();
				send_tri(f, -1);
			end
		end

		fork
			begin
				drain_pipe();
			end
			begin
				repeat (200000) @(posedge clk);
				timed_out = 1;
			end
		join_any
		if (timed_out) begin
			$display("triangle_box_overlap_test test failed");
			$finish;
		end
		if (errors == 0)
			$display("triangle_box_overlap_test test passed");
		else
			$display("triangle_box_overlap_test test failed");
		$finish;
	end

endmodule
